// File: sv/stf_pkg.sv
// stf_pkg: shared constants for the scanline triangle fill block
// register indexes, port widths and parameter defaults; no dependencies
`default_nettype none

package stf_pkg;

  localparam int MAX_ROWS_DEF   = 1024;
  localparam int COORD_BITS_DEF = 10;
  localparam int COLOR_W        = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_X       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_Y       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_FADE    = 3'd7;

endpackage

`default_nettype wire

// File: sv/stf_channels.sv
// stf_req_if and stf_res_if: valid/ready channels of the triangle fill block
// depends on stf_pkg for the color width and the coordinate default
`default_nettype none

interface stf_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface stf_res_if #(
  parameter int CB = stf_pkg::COORD_BITS_DEF
);
  import stf_pkg::*;
  logic               valid;
  logic               ready;
  logic               pixel_valid;
  logic [CB-1:0]      pix_x;
  logic [CB-1:0]      pix_y;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               last_pixel;
  modport source (output valid, output pixel_valid, output pix_x, output pix_y,
                  output red, output green, output blue, output last_pixel,
                  input ready);
  modport sink (input valid, input pixel_valid, input pix_x, input pix_y,
                input red, input green, input blue, input last_pixel,
                output ready);
endinterface

`default_nettype wire

// File: sv/stf_edge_walk.sv
// stf_edge_walk: one-step-per-cycle line walker that emits one table write per step
// depends on stf_pkg for the coordinate default; driven by the triangle fill top level
`default_nettype none

module stf_edge_walk #(
  parameter int CB = stf_pkg::COORD_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [CB-1:0] x0,
  input  wire logic [CB-1:0] y0,
  input  wire logic [CB-1:0] x1,
  input  wire logic [CB-1:0] y1,
  output logic               wr_en,
  output logic [CB+1:0]      wr_idx,
  output logic [CB-1:0]      wr_x,
  output logic               done
);

  localparam int IW = CB + 2;
  localparam int DW = CB + 3;

  logic                 active;
  logic                 xmaj;
  logic                 dir_neg;
  logic [CB-1:0]        x, xe, y, ye;
  logic [IW-1:0]        idx;
  logic signed [DW-1:0] d, ai, bi;

  logic [CB-1:0]        dx_s, dy_s, major_s, minor_s;
  logic signed [DW-1:0] maj_sv, min_sv;
  logic [CB-1:0]        x_step;

  always_comb begin
    dx_s    = (x0 < x1) ? x1 - x0 : x0 - x1;
    dy_s    = y1 - y0;
    major_s = (dx_s > dy_s) ? dx_s : dy_s;
    minor_s = (dx_s > dy_s) ? dy_s : dx_s;
    maj_sv  = signed'(DW'(major_s));
    min_sv  = signed'(DW'(minor_s));
    x_step  = dir_neg ? x - 1'b1 : x + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      wr_en  <= 1'b0;
      done   <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      done  <= 1'b0;
      if (start) begin
        active  <= 1'b1;
        xmaj    <= dx_s > dy_s;
        dir_neg <= !(x0 < x1);
        x       <= x0;
        xe      <= x1;
        y       <= y0;
        ye      <= y1;
        ai      <= (min_sv - maj_sv) <<< 1;
        bi      <= min_sv <<< 1;
        d       <= (min_sv <<< 1) - maj_sv;
        wr_en   <= 1'b1;
        wr_idx  <= '0;
        wr_x    <= x0;
        idx     <= IW'(1);
      end else if (active) begin
        if (xmaj) begin
          if (x == xe) begin
            active <= 1'b0;
            done   <= 1'b1;
          end else begin
            x      <= x_step;
            wr_en  <= 1'b1;
            wr_idx <= idx;
            wr_x   <= x_step;
            if (!d[DW-1]) begin
              d   <= d + ai;
              idx <= idx + 1'b1;
            end else begin
              d <= d + bi;
            end
          end
        end else begin
          if (y == ye) begin
            active <= 1'b0;
            done   <= 1'b1;
          end else begin
            y      <= y + 1'b1;
            wr_en  <= 1'b1;
            wr_idx <= idx;
            idx    <= idx + 1'b1;
            if (!d[DW-1]) begin
              x    <= x_step;
              wr_x <= x_step;
              d    <= d + ai;
            end else begin
              wr_x <= x;
              d    <= d + bi;
            end
          end
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !active)
    else $error("walker restarted while busy");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |-> !active && !wr_en)
    else $error("walker done with work pending");

  a_write_order: assert property (@(posedge clk) disable iff (rst)
    (active && !start) |=> (wr_en || done))
    else $error("walker stalled");

endmodule

`default_nettype wire

// File: sv/scanline_triangle_fill.sv
// scanline_triangle_fill: fills a y-sorted triangle, one result per step transfer,
// a pixel while a fill runs. A restart transfer of a sorted triangle walks the long,
// lower and upper edges into two row tables (one write per edge step), then reads
// the first row and its min/max; a restart of an unsorted triangle ends the fill.
// Within a row each step transfer moves one column; the step that closes a row is
// followed by the table read of the next row and its min/max. Results sit in an
// output register; a step is taken only once the previous result has left or
// leaves in the same cycle. Depends on stf_pkg, stf_channels and stf_edge_walk.
`default_nettype none

module scanline_triangle_fill #(
  parameter int MAX_ROWS   = stf_pkg::MAX_ROWS_DEF,
  parameter int COORD_BITS = stf_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [stf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [stf_pkg::CFG_DATA_W-1:0] cfg_data,
  stf_req_if.sink                            req,
  stf_res_if.source                          res
);

  import stf_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SAW = $clog2(2 * MAX_ROWS);

  typedef enum logic [2:0] {
    S_DONE, S_WALK0, S_WALK1, S_WALK2, S_READ, S_LOAD, S_FILL
  } state_t;

  // configuration
  logic [CB-1:0]         bx, by, mx, my, tx, ty;
  logic [CFG_DATA_W-1:0] start_color;
  logic [COLOR_W-1:0]    row_fade;

  always_ff @(posedge clk) begin
    if (rst) begin
      bx <= '0; by <= '0; mx <= '0; my <= '0; tx <= '0; ty <= '0;
      start_color <= '0;
      row_fade    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BOTTOM_X:    bx <= cfg_data[CB-1:0];
        REG_BOTTOM_Y:    by <= cfg_data[CB-1:0];
        REG_MIDDLE_X:    mx <= cfg_data[CB-1:0];
        REG_MIDDLE_Y:    my <= cfg_data[CB-1:0];
        REG_TOP_X:       tx <= cfg_data[CB-1:0];
        REG_TOP_Y:       ty <= cfg_data[CB-1:0];
        REG_START_COLOR: start_color <= cfg_data;
        REG_ROW_FADE:    row_fade <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  state_t             state;
  logic [CB-1:0]      lat_bx, lat_by, lat_mx, lat_my, lat_tx, lat_ty;
  logic [CB-1:0]      walk_x, walk_y, row_right;
  logic [COLOR_W-1:0] cur_red, cur_green, cur_blue;
  logic               a_oob, b_oob;

  // edge walker
  logic          walk_start, walk_done;
  logic [CB-1:0] wk_x0, wk_y0, wk_x1, wk_y1;
  logic          wr_en;
  logic [CB+1:0] wr_idx;
  logic [CB-1:0] wr_x;

  stf_edge_walk #(.CB(CB)) u_walk (
    .clk    (clk),
    .rst    (rst),
    .start  (walk_start),
    .x0     (wk_x0),
    .y0     (wk_y0),
    .x1     (wk_x1),
    .y1     (wk_y1),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_x   (wr_x),
    .done   (walk_done)
  );

  // row tables: long edge, and lower/upper edges sharing one memory
  logic [CB-1:0] long_mem  [MAX_ROWS];
  logic [CB-1:0] short_mem [2*MAX_ROWS];
  logic [CB-1:0] long_q, short_q;

  logic           wr_ok, long_we, short_we;
  logic [AW-1:0]  wr_addr;
  logic [SAW-1:0] wr_saddr;

  always_comb begin
    wr_ok    = wr_en && (int'(wr_idx) < MAX_ROWS);
    long_we  = wr_ok && (state == S_WALK0);
    short_we = wr_ok && ((state == S_WALK1) || (state == S_WALK2));
    wr_addr  = AW'(wr_idx);
    wr_saddr = SAW'(wr_addr) + ((state == S_WALK2) ? SAW'(MAX_ROWS) : SAW'(0));
  end

  logic           below_mid, rd_en;
  logic [CB-1:0]  off_a, off_b;
  logic [SAW-1:0] rd_saddr;

  always_comb begin
    below_mid = walk_y < lat_my;
    off_a     = walk_y - lat_by;
    off_b     = below_mid ? walk_y - lat_by : walk_y - lat_my;
    rd_en     = state == S_READ;
    rd_saddr  = SAW'(AW'(off_b)) + (below_mid ? SAW'(0) : SAW'(MAX_ROWS));
  end

  always_ff @(posedge clk) begin
    if (long_we) long_mem[wr_addr] <= wr_x;
    if (rd_en)   long_q <= long_mem[AW'(off_a)];
  end

  always_ff @(posedge clk) begin
    if (short_we) short_mem[wr_saddr] <= wr_x;
    if (rd_en)    short_q <= short_mem[rd_saddr];
  end

  // handshake
  logic ov, in_acc, row_end, unsorted;
  logic [CB-1:0] row_a, row_b;

  assign req.ready = ((state == S_DONE) || (state == S_FILL)) && (!ov || res.ready);
  assign in_acc    = req.valid && req.ready;
  assign res.valid = ov;
  assign row_end   = walk_x == row_right;
  assign unsorted  = (by > my) || (my > ty);
  assign row_a     = a_oob ? '0 : long_q;
  assign row_b     = b_oob ? '0 : short_q;

  function automatic logic [COLOR_W-1:0] fade(input logic [COLOR_W-1:0] c,
                                              input logic [COLOR_W-1:0] f);
    return (c > f) ? c - f : c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_DONE;
      walk_start <= 1'b0;
      ov         <= 1'b0;
    end else begin
      walk_start <= 1'b0;
      if (res.ready) ov <= 1'b0;
      unique case (state)
        S_DONE, S_FILL: begin
          if (in_acc) begin
            if (req.restart) begin
              if (unsorted) begin
                state <= S_DONE;
              end else begin
                lat_bx <= bx; lat_by <= by; lat_mx <= mx;
                lat_my <= my; lat_tx <= tx; lat_ty <= ty;
                wk_x0 <= bx; wk_y0 <= by; wk_x1 <= tx; wk_y1 <= ty;
                walk_start <= 1'b1;
                cur_red    <= start_color[23:16];
                cur_green  <= start_color[15:8];
                cur_blue   <= start_color[7:0];
                walk_y     <= by;
                state      <= S_WALK0;
              end
            end else begin
              ov <= 1'b1;
              if (state == S_FILL) begin
                res.pixel_valid <= 1'b1;
                res.pix_x       <= walk_x;
                res.pix_y       <= walk_y;
                res.red         <= cur_red;
                res.green       <= cur_green;
                res.blue        <= cur_blue;
                res.last_pixel  <= 1'b0;
                if (row_end) begin
                  cur_red   <= fade(cur_red, row_fade);
                  cur_green <= fade(cur_green, row_fade);
                  cur_blue  <= fade(cur_blue, row_fade);
                  if (walk_y >= lat_ty) begin
                    res.last_pixel <= 1'b1;
                    state          <= S_DONE;
                  end else begin
                    walk_y <= walk_y + 1'b1;
                    state  <= S_READ;
                  end
                end else begin
                  walk_x <= walk_x + 1'b1;
                end
              end else begin
                res.pixel_valid <= 1'b0;
                res.pix_x       <= '0;
                res.pix_y       <= '0;
                res.red         <= '0;
                res.green       <= '0;
                res.blue        <= '0;
                res.last_pixel  <= 1'b0;
              end
            end
          end
        end
        S_WALK0: begin
          if (walk_done) begin
            wk_x0 <= lat_bx; wk_y0 <= lat_by; wk_x1 <= lat_mx; wk_y1 <= lat_my;
            walk_start <= 1'b1;
            state      <= S_WALK1;
          end
        end
        S_WALK1: begin
          if (walk_done) begin
            wk_x0 <= lat_mx; wk_y0 <= lat_my; wk_x1 <= lat_tx; wk_y1 <= lat_ty;
            walk_start <= 1'b1;
            state      <= S_WALK2;
          end
        end
        S_WALK2: begin
          if (walk_done) state <= S_READ;
        end
        S_READ: begin
          a_oob <= int'(off_a) >= MAX_ROWS;
          b_oob <= int'(off_b) >= MAX_ROWS;
          state <= S_LOAD;
        end
        S_LOAD: begin
          walk_x    <= (row_a < row_b) ? row_a : row_b;
          row_right <= (row_a < row_b) ? row_b : row_a;
          state     <= S_FILL;
        end
        default: state <= S_DONE;
      endcase
    end
  end

  a_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_WALK0 || state == S_WALK1 || state == S_WALK2))
    else $error("table write outside an edge walk");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK0 || state == S_WALK1 || state == S_WALK2 ||
     state == S_READ || state == S_LOAD) |-> !req.ready)
    else $error("transfer taken during setup");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (walk_x <= row_right))
    else $error("column ran past row end");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !req.restart && state == S_FILL && row_end && walk_y >= lat_ty)
      |=> (state == S_DONE && ov && res.last_pixel))
    else $error("final pixel did not end the fill");

endmodule

`default_nettype wire

// File: tb/tb_scanline_triangle_fill.sv
// tb_scanline_triangle_fill: self-checking bench for the scanline triangle fill block
// predicts every pixel from its own edge walker and span logic, checks each result transfer
// depends on stf_pkg, stf_channels and scanline_triangle_fill
`default_nettype none

module tb_scanline_triangle_fill;
  timeunit 1ns;
  timeprecision 1ps;

  import stf_pkg::*;

  localparam int          TABLE_ROWS   = MAX_ROWS_DEF;
  localparam int          CYCLE_LIMIT  = 2_000_000;
  localparam int          RANDOM_ITEMS = 700;
  localparam int          LONG_EDGE    = 0;
  localparam int          LOWER_EDGE   = 1;
  localparam int          UPPER_EDGE   = 2;

  typedef struct packed {
    logic       pixel_valid;
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } pixel_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  stf_req_if req_ch ();
  stf_res_if res_ch ();

  scanline_triangle_fill i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  // predictor state
  bit [23:0] tri_regs [8];
  bit [23:0] staged [8];
  bit [9:0]  edge_x [3][TABLE_ROWS];
  bit        fill_active;
  int        lat_bottom, lat_mid, lat_top;
  int        row_y, span_x, span_right;
  bit [7:0]  cur_r, cur_g, cur_b;

  pixel_t      pending_pixels [$];
  int unsigned cycle_count;
  int unsigned restart_cycle;
  int unsigned walk_budget;
  int          items_sent;
  int          error_count;
  bit          steady;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int edge_span(input int x0, input int y0, input int x1, input int y1);
    int dx, dy;
    dx = (x0 > x1) ? x0 - x1 : x1 - x0;
    dy = (y0 > y1) ? y0 - y1 : y1 - y0;
    return (dx > dy) ? dx : dy;
  endfunction

  function automatic bit [7:0] faded(input bit [7:0] c);
    bit [7:0] f;
    f = tri_regs[REG_ROW_FADE][7:0];
    return (c > f) ? c - f : c;
  endfunction

  function automatic string describe(input pixel_t p);
    return $sformatf("v%0b x%0d y%0d c%02h%02h%02h l%0b",
                     p.pixel_valid, p.x, p.y, p.r, p.g, p.b, p.last);
  endfunction

  task automatic trace_edge(input int tab, input int x0, input int y0, input int x1,
                            input int y1);
    int x, y, stp, dx, dy, ai, bi, d, idx;
    x   = x0;
    y   = y0;
    stp = (x0 < x1) ? 1 : -1;
    dx  = (x0 < x1) ? x1 - x0 : x0 - x1;
    dy  = y1 - y0;
    edge_x[tab][0] = 10'(x);
    idx = 1;
    if (dx > dy) begin
      ai = (dy - dx) * 2;
      bi = dy * 2;
      d  = bi - dx;
      while (x != x1) begin
        x += stp;
        if (idx < TABLE_ROWS) edge_x[tab][idx] = 10'(x);
        if (d >= 0) begin
          d += ai;
          idx++;
        end else begin
          d += bi;
        end
      end
    end else begin
      ai = (dx - dy) * 2;
      bi = dx * 2;
      d  = bi - dy;
      while (y != y1) begin
        y++;
        if (d >= 0) begin
          x += stp;
          d += ai;
        end else begin
          d += bi;
        end
        if (idx < TABLE_ROWS) edge_x[tab][idx] = 10'(x);
        idx++;
      end
    end
  endtask

  task automatic load_span();
    bit [9:0] a, b;
    a = edge_x[LONG_EDGE][row_y - lat_bottom];
    if (row_y < lat_mid) b = edge_x[LOWER_EDGE][row_y - lat_bottom];
    else b = edge_x[UPPER_EDGE][row_y - lat_mid];
    span_x     = (a < b) ? a : b;
    span_right = (a < b) ? b : a;
  endtask

  task automatic restart_fill();
    int bx, by, mx, my, tx, ty;
    bx = tri_regs[REG_BOTTOM_X];
    by = tri_regs[REG_BOTTOM_Y];
    mx = tri_regs[REG_MIDDLE_X];
    my = tri_regs[REG_MIDDLE_Y];
    tx = tri_regs[REG_TOP_X];
    ty = tri_regs[REG_TOP_Y];
    walk_budget = 2 * (edge_span(bx, by, tx, ty) + edge_span(bx, by, mx, my) +
                       edge_span(mx, my, tx, ty)) + 40;
    fill_active = 1'b0;
    if (by > my || my > ty) return;
    lat_bottom = by;
    lat_mid    = my;
    lat_top    = ty;
    trace_edge(LONG_EDGE, bx, by, tx, ty);
    trace_edge(LOWER_EDGE, bx, by, mx, my);
    trace_edge(UPPER_EDGE, mx, my, tx, ty);
    cur_r = tri_regs[REG_START_COLOR][23:16];
    cur_g = tri_regs[REG_START_COLOR][15:8];
    cur_b = tri_regs[REG_START_COLOR][7:0];
    row_y = lat_bottom;
    load_span();
    fill_active = 1'b1;
  endtask

  task automatic emit_pixel(output pixel_t px);
    px = '0;
    if (fill_active) begin
      px.pixel_valid = 1'b1;
      px.x = 10'(span_x);
      px.y = 10'(row_y);
      px.r = cur_r;
      px.g = cur_g;
      px.b = cur_b;
      if (span_x == span_right) begin
        cur_r = faded(cur_r);
        cur_g = faded(cur_g);
        cur_b = faded(cur_b);
        if (row_y >= lat_top) begin
          px.last = 1'b1;
          fill_active = 1'b0;
        end else begin
          row_y++;
          load_span();
        end
      end else begin
        span_x = (span_x + 1) & 10'h3FF;
      end
    end
  endtask

  task automatic send_req(input bit restart_bit);
    int     gap;
    pixel_t px;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid   <= 1'b0;
      req_ch.restart <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.restart <= restart_bit;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    if (restart_bit) begin
      restart_fill();
      restart_cycle = cycle_count;
    end else begin
      emit_pixel(px);
      pending_pixels.push_back(px);
    end
  endtask

  task automatic drain_and_settle();
    req_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (cycle_count - restart_cycle < walk_budget) @(posedge clk);
  endtask

  task automatic write_regs(input bit [7:0] sel);
    bit [23:0] mask;
    for (int i = 0; i < 8; i++) begin
      if (sel[i]) begin
        case (CFG_IDX_W'(i))
          REG_START_COLOR: mask = 24'hFFFFFF;
          REG_ROW_FADE:    mask = 24'h0000FF;
          default:         mask = 24'h0003FF;
        endcase
        cfg_write <= 1'b1;
        cfg_index <= CFG_IDX_W'(i);
        cfg_data  <= staged[i];
        @(posedge clk);
        tri_regs[i] = staged[i] & mask;
      end
    end
    cfg_write <= 1'b0;
  endtask

  task automatic set_triangle(input int bx, input int by, input int mx, input int my,
                              input int tx, input int ty, input bit [23:0] color,
                              input bit [7:0] fade);
    drain_and_settle();
    staged[REG_BOTTOM_X]    = 24'(bx);
    staged[REG_BOTTOM_Y]    = 24'(by);
    staged[REG_MIDDLE_X]    = 24'(mx);
    staged[REG_MIDDLE_Y]    = 24'(my);
    staged[REG_TOP_X]       = 24'(tx);
    staged[REG_TOP_Y]       = 24'(ty);
    staged[REG_START_COLOR] = color;
    staged[REG_ROW_FADE]    = 24'(fade);
    write_regs(8'hFF);
  endtask

  task automatic fill_triangle(input int cap, input int extra);
    int n;
    send_req(1'b1);
    for (n = 0; fill_active && n < cap; n++) send_req(1'b0);
    repeat (extra) send_req(1'b0);
  endtask

  // steps before any restart, then the all-zero reset triangle
  task automatic test_before_restart();
    send_req(1'b0);
    send_req(1'b0);
    fill_triangle(4, 1);
  endtask

  // single point at the far corner with full color, then fade around a channel value
  task automatic test_extremes();
    set_triangle(1023, 1023, 1023, 1023, 1023, 1023, 24'hFFFFFF, 8'hFF);
    fill_triangle(4, 1);
    set_triangle(1, 0, 0, 1, 1, 1, 24'h80FF7F, 8'h7F);
    fill_triangle(6, 1);
  endtask

  task automatic test_unsorted();
    set_triangle(5, 9, 6, 4, 7, 12, 24'h00FF00, 8'h01);
    send_req(1'b1);
    send_req(1'b0);
    set_triangle(5, 1, 6, 9, 7, 3, 24'hFF0000, 8'h02);
    send_req(1'b1);
    send_req(1'b0);
  endtask

  // full-height triangle, restarted while its fill is running
  task automatic test_large_triangle();
    set_triangle(0, 0, 1023, 512, 0, 1023, 24'h123456, 8'h10);
    send_req(1'b1);
    repeat (3) send_req(1'b0);
    send_req(1'b1);
    repeat (2) send_req(1'b0);
  endtask

  task automatic test_random_fills();
    int       s, ox, oy, kind, cap, act, k, first;
    int       vx [3];
    int       vy [3];
    bit [7:0] sel;
    bit [7:0] fade;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      drain_and_settle();
      steady = ($urandom_range(0, 4) == 0);
      kind   = $urandom_range(0, 99);
      if (kind < 4) s = $urandom_range(100, 1023);
      else if ($urandom_range(0, 9) < 8) s = $urandom_range(0, 6);
      else s = $urandom_range(7, 14);
      ox = $urandom_range(0, 1023 - s);
      oy = $urandom_range(0, 1023 - s);
      if ($urandom_range(0, 6) == 0) ox = $urandom_range(0, 1) ? 0 : 1023 - s;
      if ($urandom_range(0, 6) == 0) oy = $urandom_range(0, 1) ? 0 : 1023 - s;
      for (int i = 0; i < 3; i++) begin
        vx[i] = ox + $urandom_range(0, s);
        vy[i] = oy + $urandom_range(0, s);
      end
      if (vy[0] > vy[1]) {vy[0], vy[1]} = {vy[1], vy[0]};
      if (vy[1] > vy[2]) {vy[1], vy[2]} = {vy[2], vy[1]};
      if (vy[0] > vy[1]) {vy[0], vy[1]} = {vy[1], vy[0]};
      if (kind >= 4 && kind < 12) begin
        if (vy[0] < vy[1]) {vy[0], vy[1]} = {vy[1], vy[0]};
        else if (vy[1] < vy[2]) {vy[1], vy[2]} = {vy[2], vy[1]};
        else if (vy[1] < 1023) vy[0] = vy[1] + 1;
        else vy[1] = vy[1] - 1;
      end
      staged[REG_BOTTOM_X] = {14'($urandom), 10'(vx[0])};
      staged[REG_BOTTOM_Y] = {14'($urandom), 10'(vy[0])};
      staged[REG_MIDDLE_X] = {14'($urandom), 10'(vx[1])};
      staged[REG_MIDDLE_Y] = {14'($urandom), 10'(vy[1])};
      staged[REG_TOP_X]    = {14'($urandom), 10'(vx[2])};
      staged[REG_TOP_Y]    = {14'($urandom), 10'(vy[2])};
      k = $urandom_range(0, 9);
      staged[REG_START_COLOR] = (k == 0) ? 24'hFFFFFF : (k == 1) ? 24'h0 : 24'($urandom);
      k = $urandom_range(0, 9);
      if (k == 0) fade = 8'h00;
      else if (k == 1) fade = 8'hFF;
      else if (k < 5) fade = 8'($urandom_range(1, 8));
      else fade = 8'($urandom);
      staged[REG_ROW_FADE] = {16'($urandom), fade};
      sel = ($urandom_range(0, 4) != 0) ? 8'hFF : 8'($urandom);
      write_regs(sel);
      cap = (s > 14 || sel != 8'hFF) ? 30 : 250;
      act = $urandom_range(0, 9);
      if (act < 7) begin
        fill_triangle(cap, $urandom_range(0, 2));
      end else if (act == 7) begin
        send_req(1'b1);
        repeat ($urandom_range(1, 6)) send_req(1'b0);
        fill_triangle(cap, $urandom_range(0, 2));
      end else if (act == 8) begin
        // carry on with any fill already running; only the row fade takes the new setting
        for (k = 0; fill_active && k < cap; k++) send_req(1'b0);
        send_req(1'b0);
      end else begin
        repeat ($urandom_range(3, 10)) send_req($urandom_range(0, 9) < 3);
      end
    end
    steady = 1'b0;
  endtask

  // result side: random back-pressure
  initial begin
    res_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      int n;
      n = pick_gap();
      if (n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = {res_ch.pixel_valid, res_ch.pix_x, res_ch.pix_y, res_ch.red, res_ch.green,
             res_ch.blue, res_ch.last_pixel};
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result transfer, got %s", $time, describe(got));
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          $display("%0t: expected %s, got %s", $time, describe(want), describe(got));
          error_count++;
        end
      end
    end
  end

  initial begin
    req_ch.valid   = 1'b0;
    req_ch.restart = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_restart();
    test_extremes();
    test_unsorted();
    test_large_triangle();
    test_random_fills();
    drain_and_settle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
sv/stf_pkg.sv
sv/stf_channels.sv
sv/stf_edge_walk.sv
sv/scanline_triangle_fill.sv
tb/tb_scanline_triangle_fill.sv
